/* sv/first_fit_block_allocator_unit_macros.svh */
// assertion macros for the first-fit block allocator
// used by first_fit_block_allocator_unit; expects clk_i and rst_ni in scope
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// property must hold at every clock edge outside reset
`define FFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define FFA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* sv/ffa_pkg.sv */
// shared types and constants of the first-fit block allocator
// no dependencies; used by ffa_stream_if users and first_fit_block_allocator_unit
package ffa_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned LIMIT_W    = 25;
  localparam int unsigned REQ_W      = 24;
  localparam int unsigned SIZE_W     = 25;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned MAX_BLOCKS_DEF   = 256;
  localparam int unsigned HEADER_BYTES_DEF = 12;
  localparam int unsigned ALIGN_BYTES_DEF  = 8;

  // growth never passes 16 MiB whatever the limit register says
  localparam logic [SIZE_W-1:0]  GROW_CAP       = 25'h100_0000;
  localparam logic [LIMIT_W-1:0] HEAP_LIMIT_RST = 25'd65536;

  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESIZE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOMEM   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] user_address;
    logic [REQ_W-1:0]  request_bytes;
  } ffa_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   result_address;
    logic                copy_needed;
    logic [ADDR_W-1:0]   copy_from;
    logic [REQ_W-1:0]    copy_bytes;
  } ffa_rsp_t;

  // one row of the block table
  typedef struct packed {
    logic              is_free;
    logic [SIZE_W-1:0] blk_bytes;
    logic [SIZE_W-1:0] offset;
  } ffa_entry_t;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_RESIZE,
    OP_NONE
  } ffa_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROUND,
    S_PREP,
    S_FIND,
    S_FOUND,
    S_ALLOC,
    S_TAKE,
    S_APPEND,
    S_RELEASE,
    S_DONE
  } ffa_state_e;

endpackage

/* sv/ffa_stream_if.sv */
// valid/ready stream channel carrying one payload per transaction
// payload type is set per instance; no package dependency
interface ffa_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/first_fit_block_allocator_unit.sv */
// first-fit block allocator: one request in, one result out, one request at a time.
// a request first rounds the byte count (S_ROUND), then adds padding and header (S_PREP);
// allocate and free scan the table at most once, a resize that moves scans it twice; both
// table scans read one entry per cycle. a new request is taken only once the last one reaches
// S_DONE and loads its result; a new request is taken while a result waits.
// reset: block count and heap top clear, registers take their reset values; entries undefined.
module first_fit_block_allocator_unit #(
  parameter int unsigned MAX_BLOCKS   = ffa_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
  parameter int unsigned ALIGN_BYTES  = ffa_pkg::ALIGN_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ffa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ffa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  ffa_stream_if.sink                      req_i,
  ffa_stream_if.source                    rsp_o
);
  import ffa_pkg::*;

  `include "first_fit_block_allocator_unit_macros.svh"

  // table index and count widths
  localparam int unsigned IW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW  = $clog2(MAX_BLOCKS + 1);
  // remainder estimate holds up to twice the alignment before correction
  localparam int unsigned RMW = $clog2(ALIGN_BYTES) + 1;
  localparam int unsigned PW  = 2 * REQ_W;
  localparam int unsigned RCW = REQ_W + 1;

  localparam logic [RMW-1:0]    ALN      = RMW'(ALIGN_BYTES);
  localparam logic [SIZE_W-1:0] HDR      = SIZE_W'(HEADER_BYTES);
  localparam logic [ADDR_W-1:0] HDR_ADDR = ADDR_W'(HEADER_BYTES);
  localparam logic [CW-1:0]     CNT_MAX  = CW'(MAX_BLOCKS);
  // reciprocal of the alignment scaled by 2^REQ_W, rounded down
  localparam logic [RCW-1:0]    RECIP    = RCW'((1 << REQ_W) / ALIGN_BYTES);

  // block table: one write port, one registered read port
  ffa_entry_t blk_mem [MAX_BLOCKS];
  ffa_entry_t rd_q;
  logic [IW-1:0] rd_addr;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  ffa_entry_t    mem_wd;

  // control state
  ffa_state_e          state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [LIMIT_W-1:0]  top_q, top_d;
  logic [ADDR_W-1:0]   base_q, base_d;
  logic [LIMIT_W-1:0]  limit_q, limit_d;
  logic                out_valid_q, out_valid_d;
  logic [CW-1:0]       scan_q, scan_d;
  logic                pend_q, pend_d;
  logic                phase_q, phase_d;

  // transaction payload and working registers
  ffa_op_e             op_q, op_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [REQ_W-1:0]    req_q, req_d;
  logic [REQ_W-1:0]    quo_q, quo_d;
  logic [RMW-1:0]      rem_q, rem_d;
  logic [ADDR_W-1:0]   target_q, target_d;
  logic [SIZE_W-1:0]   total_q, total_d;
  logic [IW-1:0]       pidx_q, pidx_d;
  ffa_entry_t          hit_q, hit_d;
  logic [IW-1:0]       hit_idx_q, hit_idx_d;
  ffa_entry_t          new_q, new_d;
  logic [IW-1:0]       new_idx_q, new_idx_d;
  logic [STATUS_W-1:0] st_q, st_d;
  logic [ADDR_W-1:0]   res_q, res_d;
  logic                cneed_q, cneed_d;
  ffa_rsp_t            out_q, out_d;

  // shared combinational terms
  logic               accept;
  logic               in_scan;
  logic               issue;
  logic               match;
  logic               scan_hit;
  logic               scan_miss;
  logic [PW-1:0]      prod;
  logic [RMW-1:0]     rem_raw;
  logic [RMW-1:0]     rem_fix;
  logic [RMW-1:0]     pad;
  logic [SIZE_W-1:0]  prev_payload;
  logic               old_fits;
  logic [SIZE_W-1:0]  grow_lim;
  logic               room;
  logic               grow_ok;
  logic               out_load;

  assign req_i.ready   = (state_q == S_IDLE);
  assign accept        = req_i.valid && (state_q == S_IDLE);
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  // table scan: read issued at scan_q, data for pidx_q compared in the cycle after
  assign in_scan   = (state_q == S_FIND) || (state_q == S_ALLOC);
  assign issue     = scan_q < count_q;
  assign rd_addr   = scan_q[IW-1:0];
  assign match     = (state_q == S_FIND) ? (ADDR_W'(rd_q.offset) == target_q)
                                         : (rd_q.is_free && (rd_q.blk_bytes >= total_q));
  assign scan_hit  = in_scan && pend_q && match;
  assign scan_miss = in_scan && !pend_q && !issue;

  // remainder by the alignment through a reciprocal multiply; the quotient estimate
  // is at most one low, so one conditional subtract corrects the remainder
  assign prod    = PW'(req_q) * PW'(RECIP);
  assign rem_raw = req_q[RMW-1:0] - quo_q[RMW-1:0] * ALN;
  assign rem_fix = (rem_raw >= ALN) ? (rem_raw - ALN) : rem_raw;

  assign pad          = (rem_q == '0) ? '0 : (ALN - rem_q);
  assign prev_payload = hit_q.blk_bytes - HDR;
  assign old_fits     = prev_payload >= SIZE_W'(req_q);
  assign grow_lim     = (limit_q < GROW_CAP) ? limit_q : GROW_CAP;
  assign room         = count_q < CNT_MAX;
  assign grow_ok      = ({1'b0, top_q} + {1'b0, total_q}) <= {1'b0, grow_lim};
  assign out_load     = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) state_d = S_ROUND;
      end
      S_ROUND: begin
        if (phase_q) state_d = S_PREP;
      end
      S_PREP: begin
        case (op_q)
          OP_ALLOC:  state_d = S_ALLOC;
          OP_FREE:   state_d = (addr_q == '0) ? S_DONE : S_FIND;
          OP_RESIZE: state_d = S_FIND;
          default:   state_d = S_DONE;
        endcase
      end
      S_FIND: begin
        if (scan_hit) state_d = S_FOUND;
        else if (scan_miss) state_d = S_DONE;
      end
      S_FOUND: begin
        if (op_q == OP_FREE) state_d = S_RELEASE;
        else if (old_fits) state_d = S_DONE;
        else state_d = S_ALLOC;
      end
      S_ALLOC: begin
        if (scan_hit) state_d = S_TAKE;
        else if (scan_miss) state_d = S_APPEND;
      end
      S_TAKE: begin
        state_d = (op_q == OP_RESIZE) ? S_RELEASE : S_DONE;
      end
      S_APPEND: begin
        state_d = (room && grow_ok && (op_q == OP_RESIZE)) ? S_RELEASE : S_DONE;
      end
      S_RELEASE: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // datapath, table writes and result register
  always_comb begin
    count_d     = count_q;
    top_d       = top_q;
    base_d      = base_q;
    limit_d     = limit_q;
    scan_d      = scan_q;
    pend_d      = 1'b0;
    pidx_d      = pidx_q;
    phase_d     = phase_q;
    op_d        = op_q;
    addr_d      = addr_q;
    req_d       = req_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    target_d    = target_q;
    total_d     = total_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    new_d       = new_q;
    new_idx_d   = new_idx_q;
    st_d        = st_q;
    res_d       = res_q;
    cneed_d     = cneed_q;
    mem_we      = 1'b0;
    mem_wa      = hit_idx_q;
    mem_wd      = hit_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !rsp_o.ready;

    // configuration writes must arrive only while idle; the block itself does not enforce this
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEAP_BASE:  base_d = cfg_data_i[ADDR_W-1:0];
        CFG_HEAP_LIMIT: limit_d = cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end

    // scan pointer steps while no decision is made and entries remain, rewinds outside the scans
    if (in_scan) begin
      if (!scan_hit && !scan_miss) begin
        pend_d = issue;
        pidx_d = scan_q[IW-1:0];
        scan_d = scan_q + CW'(issue);
      end
    end else begin
      scan_d = '0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.payload.kind)
            KIND_ALLOC: op_d = OP_ALLOC;
            KIND_FREE:  op_d = OP_FREE;
            KIND_RESIZE: begin
              // resize of nothing allocates, resize to nothing frees
              if (req_i.payload.user_address == '0) op_d = OP_ALLOC;
              else if (req_i.payload.request_bytes == '0) op_d = OP_FREE;
              else op_d = OP_RESIZE;
            end
            default: op_d = OP_NONE;
          endcase
          addr_d   = req_i.payload.user_address;
          req_d    = req_i.payload.request_bytes;
          // offset that the address would have: addr - base - header
          target_d = req_i.payload.user_address - base_q - HDR_ADDR;
          rem_d    = '0;
          phase_d  = 1'b0;
          st_d     = ST_OK;
          res_d    = '0;
          cneed_d  = 1'b0;
        end
      end
      S_ROUND: begin
        // first phase estimates the quotient, second phase settles the remainder
        if (!phase_q) quo_d = REQ_W'(prod >> REQ_W);
        else rem_d = rem_fix;
        phase_d = !phase_q;
      end
      S_PREP: begin
        // aligned byte count plus header
        total_d = SIZE_W'(req_q) + SIZE_W'(pad) + HDR;
      end
      S_FIND: begin
        if (scan_hit) begin
          hit_d     = rd_q;
          hit_idx_d = pidx_q;
        end else if (scan_miss) begin
          st_d = ST_UNKNOWN;
        end
      end
      S_FOUND: begin
        if ((op_q == OP_RESIZE) && old_fits) res_d = addr_q;
      end
      S_ALLOC: begin
        if (scan_hit) begin
          new_d     = rd_q;
          new_idx_d = pidx_q;
        end
      end
      S_TAKE: begin
        // reuse without splitting
        mem_we         = 1'b1;
        mem_wa         = new_idx_q;
        mem_wd         = new_q;
        mem_wd.is_free = 1'b0;
        res_d          = base_q + ADDR_W'(new_q.offset) + HDR_ADDR;
      end
      S_APPEND: begin
        if (room && grow_ok) begin
          mem_we           = 1'b1;
          mem_wa           = count_q[IW-1:0];
          mem_wd.is_free   = 1'b0;
          mem_wd.blk_bytes = total_q;
          mem_wd.offset    = top_q;
          count_d          = count_q + CW'(1);
          top_d            = top_q + total_q;
          res_d            = base_q + ADDR_W'(top_q) + HDR_ADDR;
        end else begin
          st_d = ST_NOMEM;
        end
      end
      S_RELEASE: begin
        // free the found block; on a resize this is the old block after the move
        mem_we         = 1'b1;
        mem_wa         = hit_idx_q;
        mem_wd         = hit_q;
        mem_wd.is_free = 1'b1;
        cneed_d        = (op_q == OP_RESIZE);
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_d           = 1'b1;
          out_d.status          = st_q;
          out_d.result_address  = res_q;
          out_d.copy_needed     = cneed_q;
          out_d.copy_from       = cneed_q ? addr_q : '0;
          out_d.copy_bytes      = cneed_q ? prev_payload[REQ_W-1:0] : '0;
        end
      end
      default: ;
    endcase
  end

  // block table
  always_ff @(posedge clk_i) begin
    if (mem_we) blk_mem[mem_wa] <= mem_wd;
    rd_q <= blk_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      top_q       <= '0;
      base_q      <= '0;
      limit_q     <= HEAP_LIMIT_RST;
      out_valid_q <= 1'b0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      top_q       <= top_d;
      base_q      <= base_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    addr_q    <= addr_d;
    req_q     <= req_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    target_q  <= target_d;
    total_q   <= total_d;
    pidx_q    <= pidx_d;
    hit_q     <= hit_d;
    hit_idx_q <= hit_idx_d;
    new_q     <= new_d;
    new_idx_q <= new_idx_d;
    st_q      <= st_d;
    res_q     <= res_d;
    cneed_q   <= cneed_d;
    out_q     <= out_d;
  end

  // checks on table bookkeeping and result consistency
  `FFA_ASSERT(a_count_bound, count_q <= CNT_MAX, "block count above table size")
  `FFA_ASSERT(a_top_cap, top_q <= GROW_CAP, "heap top above growth cap")
  `FFA_ASSERT(a_top_on_append, !$stable(top_q) |-> $past(state_q) == S_APPEND, "heap top moved outside append")
  `FFA_ASSERT_NEVER(a_read_past_count, pend_q && (CW'(pidx_q) >= count_q), "scan compared an entry past the count")
  `FFA_ASSERT(a_copy_ok, rsp_o.valid && rsp_o.payload.copy_needed |-> rsp_o.payload.status == ST_OK && rsp_o.payload.copy_from != '0, "copy reported on a failed or empty move")
  `FFA_ASSERT(a_unknown_clean, rsp_o.valid && rsp_o.payload.status == ST_UNKNOWN |-> rsp_o.payload.result_address == '0 && !rsp_o.payload.copy_needed, "unknown address result carries data")

endmodule
